[rtl/cache_key_tag_parser_unit_macros.svh]
// Assertion macros for the cache key tag parser RTL.
`ifndef CACHE_KEY_TAG_PARSER_UNIT_MACROS_SVH
`define CACHE_KEY_TAG_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CKP_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ckp assertion failed");

`define CKP_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ckp assertion failed");

`define CKP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ckp assertion failed");

`else

`define CKP_ASSERT(name, prop)
`define CKP_ASSERT_IMPL(name, ante, cons)
`define CKP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[rtl/ckp_pkg.sv]
// Types, character codes and register map of the cache key tag parser.
`timescale 1ns / 1ps
package ckp_pkg;

	localparam int APB_ADDR_W = 3;

	typedef enum logic [0:0] {
		REG_DEFAULT_ID = 1'b0
	} reg_idx_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [4:0] {
		MODE_TAG   = 5'b00001,
		MODE_COMMA = 5'b00010,
		MODE_VALUE = 5'b00100,
		MODE_KEY   = 5'b01000,
		MODE_ERROR = 5'b10000
	} mode_t;

	// flags: bit0 private, bit1 in-browser, bit2 anonymous
	typedef struct packed {
		mode_t       mode;
		logic        comma_pending;
		logic        value_is_app;
		logic [31:0] acc;
		logic        digit_seen;
		logic        value_bad;
		logic [2:0]  flags;
		logic [31:0] app_held;
		logic        id_from_tag;
	} parse_state_t;

	localparam parse_state_t PARSE_STATE_RST = '{
		mode:          MODE_TAG,
		comma_pending: 1'b0,
		value_is_app:  1'b0,
		acc:           32'd0,
		digit_seen:    1'b0,
		value_bad:     1'b0,
		flags:         3'b000,
		app_held:      32'd0,
		id_from_tag:   1'b0
	};

	typedef struct packed {
		logic [7:0]  cache_key_byte;
		logic        cache_key_valid;
		logic        parse_done;
		logic        parse_ok;
		logic        private_out;
		logic        in_browser_out;
		logic        anonymous_out;
		logic [31:0] app_id_out;
	} parse_res_t;

endpackage

[rtl/ckp_in_if.sv]
// Input channel: one key byte word per handshake.
`timescale 1ns / 1ps
interface ckp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	logic       byte_present;
	logic       last_byte;

	modport source (output valid, key_byte, byte_present, last_byte, input ready);
	modport sink (input valid, key_byte, byte_present, last_byte, output ready);
endinterface

[rtl/ckp_out_if.sv]
// Output channel: one parse result word per handshake.
`timescale 1ns / 1ps
interface ckp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  cache_key_byte;
	logic        cache_key_valid;
	logic        parse_done;
	logic        parse_ok;
	logic        private_out;
	logic        in_browser_out;
	logic        anonymous_out;
	logic [31:0] app_id_out;

	modport source (output valid, cache_key_byte, cache_key_valid, parse_done, parse_ok,
		private_out, in_browser_out, anonymous_out, app_id_out, input ready);
	modport sink (input valid, cache_key_byte, cache_key_valid, parse_done, parse_ok,
		private_out, in_browser_out, anonymous_out, app_id_out, output ready);
endinterface

[rtl/ckp_step.sv]
// Per-byte next-state and result logic of the tag list parser.
`timescale 1ns / 1ps
module ckp_step (
	input  ckp_pkg::parse_state_t st,
	input  logic [7:0]            key_byte,
	input  logic                  byte_present,
	input  logic                  last_byte,
	input  logic [31:0]           default_id,
	output ckp_pkg::parse_state_t st_nxt,
	output ckp_pkg::parse_res_t   res
);
	import ckp_pkg::*;

	function automatic parse_state_t take_tag(parse_state_t s, logic [7:0] b);
		parse_state_t r;
		r = s;
		case (b)
			CH_COLON: r.mode = MODE_KEY;
			CH_P: begin
				r.flags[0] = 1'b1;
				r.mode = MODE_COMMA;
			end
			CH_B: begin
				r.flags[1] = 1'b1;
				r.mode = MODE_COMMA;
			end
			CH_A: begin
				r.flags[2] = 1'b1;
				r.mode = MODE_COMMA;
			end
			default: begin
				r.mode = MODE_VALUE;
				r.comma_pending = 1'b0;
				r.value_is_app = (b == CH_I);
				r.acc = '0;
				r.digit_seen = 1'b0;
				r.value_bad = 1'b0;
			end
		endcase
		return r;
	endfunction

	parse_state_t n;
	logic [35:0]  acc_x10;
	logic         close_ok;
	logic         fin_ok;
	logic [31:0]  fin_id;
	logic [31:0]  cur_id;

	// acc*10 + digit; bits above 31 mean overflow
	assign acc_x10 = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0}
		+ {32'd0, key_byte[3:0]};

	assign close_ok = !st.value_is_app || (!st.value_bad && st.digit_seen);

	always_comb begin
		n = st;
		res = '0;
		fin_ok = 1'b0;
		fin_id = '0;
		cur_id = '0;
		if (byte_present) begin
			case (st.mode)
				MODE_KEY: begin
					res.cache_key_byte = key_byte;
					res.cache_key_valid = 1'b1;
				end
				MODE_TAG: n = take_tag(st, key_byte);
				MODE_COMMA: n.mode = (key_byte == CH_COMMA) ? MODE_TAG : MODE_ERROR;
				MODE_VALUE: begin
					if (key_byte == CH_COMMA) begin
						// doubled comma is an escaped comma inside the value
						if (st.comma_pending) begin
							n.comma_pending = 1'b0;
							if (st.value_is_app)
								n.value_bad = 1'b1;
						end else begin
							n.comma_pending = 1'b1;
						end
					end else if (st.comma_pending) begin
						n.comma_pending = 1'b0;
						if (close_ok) begin
							if (st.value_is_app) begin
								n.app_held = st.acc;
								n.id_from_tag = 1'b1;
							end
							n = take_tag(n, key_byte);
						end else begin
							n.mode = MODE_ERROR;
						end
					end else if (st.value_is_app && !st.value_bad) begin
						if (key_byte inside {[CH_0:CH_9]}) begin
							if (acc_x10[35:32] != 4'd0)
								n.value_bad = 1'b1;
							else
								n.acc = acc_x10[31:0];
							n.digit_seen = 1'b1;
						end else begin
							n.value_bad = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end

		if (last_byte) begin
			cur_id = n.id_from_tag ? n.app_held : default_id;
			case (n.mode)
				MODE_TAG, MODE_KEY: begin
					fin_ok = 1'b1;
					fin_id = cur_id;
				end
				MODE_VALUE: begin
					fin_ok = n.comma_pending
						&& (!n.value_is_app || (!n.value_bad && n.digit_seen));
					fin_id = n.value_is_app ? n.acc : cur_id;
				end
				default: ;
			endcase
			res.parse_done = 1'b1;
			if (fin_ok) begin
				res.parse_ok = 1'b1;
				res.private_out = n.flags[0];
				res.in_browser_out = n.flags[1];
				res.anonymous_out = n.flags[2];
				res.app_id_out = fin_id;
			end
			n = PARSE_STATE_RST;
		end
	end

	assign st_nxt = n;
endmodule

[rtl/cache_key_tag_parser_unit.sv]
// Top level: input register, parse state, result register and APB register.
//
//  channel  | dir | words
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | key_byte, byte_present, last_byte
//  out_ch   | out | key byte, done/ok, three flags, app id; one word per input
//  APB      | in  | register 0 (0x0): default app id, 32 bits
//
// One word per cycle sustained while out_ch is ready; a word passes the input register, then the result register.
// The parse state loop (mode update plus the x10 accumulate) closes through the st_q register alone.
// Reset (arst_n low) returns the parser to tag mode and clears the default id.
// A stalled result register holds the input register; input stalls only when both are full.
`timescale 1ns / 1ps
`include "cache_key_tag_parser_unit_macros.svh"
module cache_key_tag_parser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	ckp_in_if.sink                          in_ch,
	ckp_out_if.source                       out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ckp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import ckp_pkg::*;

	logic         s1_valid;
	logic [7:0]   key_byte_s1;
	logic         present_s1;
	logic         last_s1;
	logic         out_valid_q;
	parse_res_t   res_q;
	parse_state_t st_q;
	parse_state_t st_nxt;
	parse_res_t   res_nxt;
	logic [31:0]  default_id_q;
	logic         adv;
	logic         cfg_wr;
	reg_idx_t     reg_idx;

	// register configuration
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (reg_idx == REG_DEFAULT_ID) ? default_id_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_id_q <= '0;
		end else if (cfg_wr && reg_idx == REG_DEFAULT_ID) begin
			default_id_q <= pwdata;
		end
	end

	// handshake
	assign adv = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			key_byte_s1 <= in_ch.key_byte;
			present_s1 <= in_ch.byte_present;
			last_s1 <= in_ch.last_byte;
		end
	end

	ckp_step u_step (
		.st           (st_q),
		.key_byte     (key_byte_s1),
		.byte_present (present_s1),
		.last_byte    (last_s1),
		.default_id   (default_id_q),
		.st_nxt       (st_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_STATE_RST;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid;
			if (s1_valid)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid)
			res_q <= res_nxt;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.cache_key_byte = res_q.cache_key_byte;
	assign out_ch.cache_key_valid = res_q.cache_key_valid;
	assign out_ch.parse_done = res_q.parse_done;
	assign out_ch.parse_ok = res_q.parse_ok;
	assign out_ch.private_out = res_q.private_out;
	assign out_ch.in_browser_out = res_q.in_browser_out;
	assign out_ch.anonymous_out = res_q.anonymous_out;
	assign out_ch.app_id_out = res_q.app_id_out;

	// a failed parse reports no flags and a zero id
	`CKP_ASSERT_IMPL(a_err_clean, out_valid_q && !res_q.parse_ok, !res_q.private_out && !res_q.in_browser_out && !res_q.anonymous_out && res_q.app_id_out == 32'd0)
	// the end of a key restarts the parser
	`CKP_ASSERT_NEXT(a_restart, adv && s1_valid && last_s1, st_q.mode == MODE_TAG && st_q.flags == 3'b000 && !st_q.id_from_tag)
	// a pending comma only exists inside a value
	`CKP_ASSERT_IMPL(a_pend_in_value, st_q.mode != MODE_VALUE, !st_q.comma_pending)
	// a held word in the input register is not dropped
	`CKP_ASSERT_NEXT(a_s1_hold, s1_valid && !adv, s1_valid)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the cache key tag parser: table-driven and random keys.
`timescale 1ns / 1ps
module testbench;
	import ckp_pkg::*;

	localparam logic [APB_ADDR_W-1:0] DEFAULT_ID_ADDR = APB_ADDR_W'(4 * REG_DEFAULT_ID);
	localparam int PHASE_WORDS = 185;

	typedef struct packed {
		logic [7:0] b;
		logic       present;
		logic       last;
	} key_word_t;

	typedef struct {
		key_word_t  w;
		bit         typed;
		parse_res_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	ckp_in_if  in_ch();
	ckp_out_if out_ch();

	cache_key_tag_parser_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// parser image kept alongside the block
	mode_t       pm_mode;
	bit          pm_cpend, pm_isapp, pm_digit, pm_bad, pm_fromtag;
	logic [31:0] pm_acc, pm_held, cfg_default;
	logic [2:0]  pm_flags;

	parse_res_t results_due[$];
	key_word_t  pend_words[$];
	dir_row_t   dir_rows[$];

	int gap_pct, stall_pct;
	int mismatch_count, words_in, results_seen, keys_ok, keys_bad, key_bytes_out;

	function void key_restart();
		pm_mode = MODE_TAG;
		pm_cpend = 1'b0;
		pm_isapp = 1'b0;
		pm_acc = '0;
		pm_digit = 1'b0;
		pm_bad = 1'b0;
		pm_flags = '0;
		pm_fromtag = 1'b0;
	endfunction

	function void tag_start(logic [7:0] b);
		case (b)
		CH_COLON: pm_mode = MODE_KEY;
		CH_P: begin pm_flags[0] = 1'b1; pm_mode = MODE_COMMA; end
		CH_B: begin pm_flags[1] = 1'b1; pm_mode = MODE_COMMA; end
		CH_A: begin pm_flags[2] = 1'b1; pm_mode = MODE_COMMA; end
		default: begin
			pm_mode = MODE_VALUE;
			pm_cpend = 1'b0;
			pm_isapp = (b == CH_I);
			pm_acc = '0;
			pm_digit = 1'b0;
			pm_bad = 1'b0;
		end
		endcase
	endfunction

	// a lone comma ended the value; an app id must be clean digits
	function bit value_close();
		pm_cpend = 1'b0;
		if (!pm_isapp)
			return 1'b1;
		if (pm_bad || !pm_digit)
			return 1'b0;
		pm_held = pm_acc;
		pm_fromtag = 1'b1;
		return 1'b1;
	endfunction

	function void list_byte(logic [7:0] b);
		logic [63:0] acc10;
		case (pm_mode)
		MODE_TAG: tag_start(b);
		MODE_COMMA: pm_mode = (b == CH_COMMA) ? MODE_TAG : MODE_ERROR;
		MODE_VALUE: begin
			if (b == CH_COMMA) begin
				if (pm_cpend) begin
					// doubled comma: escaped, never legal in an app id
					pm_cpend = 1'b0;
					if (pm_isapp)
						pm_bad = 1'b1;
				end else begin
					pm_cpend = 1'b1;
				end
			end else if (pm_cpend) begin
				if (value_close())
					tag_start(b);
				else
					pm_mode = MODE_ERROR;
			end else if (pm_isapp && !pm_bad) begin
				if (b >= CH_0 && b <= CH_9) begin
					acc10 = 64'(pm_acc) * 64'd10 + 64'(b - CH_0);
					if (acc10 > 64'hFFFF_FFFF)
						pm_bad = 1'b1;
					else
						pm_acc = acc10[31:0];
					pm_digit = 1'b1;
				end else begin
					pm_bad = 1'b1;
				end
			end
		end
		default: ;
		endcase
	endfunction

	function parse_res_t parse_result_for(key_word_t w);
		parse_res_t r;
		bit ok;
		r = '0;
		if (w.present) begin
			if (pm_mode == MODE_KEY) begin
				r.cache_key_byte = w.b;
				r.cache_key_valid = 1'b1;
			end else begin
				list_byte(w.b);
			end
		end
		if (w.last) begin
			case (pm_mode)
			MODE_TAG, MODE_KEY: ok = 1'b1;
			MODE_VALUE: ok = pm_cpend ? value_close() : 1'b0;
			default: ok = 1'b0;
			endcase
			r.parse_done = 1'b1;
			if (ok) begin
				r.parse_ok = 1'b1;
				r.private_out = pm_flags[0];
				r.in_browser_out = pm_flags[1];
				r.anonymous_out = pm_flags[2];
				r.app_id_out = pm_fromtag ? pm_held : cfg_default;
			end
			key_restart();
		end
		return r;
	endfunction

	function parse_res_t result_word(logic [7:0] kb, bit kv, bit done, bit ok,
			bit priv, bit inb, bit anon, logic [31:0] app);
		parse_res_t r;
		r.cache_key_byte = kb;
		r.cache_key_valid = kv;
		r.parse_done = done;
		r.parse_ok = ok;
		r.private_out = priv;
		r.in_browser_out = inb;
		r.anonymous_out = anon;
		r.app_id_out = app;
		return r;
	endfunction

	task add_row(logic [7:0] b, bit present, bit last, bit typed, parse_res_t want);
		dir_row_t row;
		row.w = '{b: b, present: present, last: last};
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task add_text(string s);
		for (int k = 0; k < s.len(); k++)
			add_row(s[k], 1'b1, 1'b0, 1'b0, '0);
	endtask

	function logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
		0: return CH_P;
		1: return CH_B;
		2: return CH_A;
		3: return CH_I;
		4: return CH_COLON;
		5: return CH_COMMA;
		6: return CH_0 + 8'($urandom_range(0, 9));
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function string app_digits();
		logic [63:0] big;
		big = {$urandom, $urandom};
		case ($urandom_range(0, 15))
		0: return "4294967295";
		1: return $sformatf("%0d", 64'd4294967296 + 64'($urandom_range(0, 999)));
		2: return "0";
		3: return $sformatf("00%0d", $urandom_range(0, 99));
		4: return $sformatf("%0d", big);
		5: return "";
		6: return $sformatf("%0d,,%0d", $urandom_range(0, 99), $urandom_range(0, 99));
		7, 8: return $sformatf("%0d", $urandom_range(0, 999));
		default: return $sformatf("%0d", $urandom);
		endcase
	endfunction

	// one key string: mostly a well-formed tag list, some of them mangled
	task gen_key();
		logic [7:0] kb[$];
		logic [7:0] tag, r;
		string digits;
		key_word_t w;
		kb.delete();
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
			0: begin kb.push_back(CH_P); kb.push_back(CH_COMMA); end
			1: begin kb.push_back(CH_B); kb.push_back(CH_COMMA); end
			2: begin kb.push_back(CH_A); kb.push_back(CH_COMMA); end
			3: begin
				kb.push_back(CH_I);
				digits = app_digits();
				for (int k = 0; k < digits.len(); k++)
					kb.push_back(digits[k]);
				kb.push_back(CH_COMMA);
			end
			default: begin
				do
					tag = 8'($urandom_range(0, 255));
				while (tag inside {CH_P, CH_B, CH_A, CH_I, CH_COLON});
				kb.push_back(tag);
				repeat ($urandom_range(0, 5)) begin
					r = 8'($urandom_range(0, 255));
					kb.push_back(r);
					if (r == CH_COMMA)
						kb.push_back(r);
				end
				kb.push_back(CH_COMMA);
			end
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			kb.push_back(CH_COLON);
			repeat ($urandom_range(0, 6))
				kb.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(99) < 20) begin
			case ($urandom_range(0, 3))
			0: if (kb.size() > 0) kb[$urandom_range(0, kb.size() - 1)] = noise_byte();
			1: if (kb.size() > 0) void'(kb.pop_back());
			2: kb.insert($urandom_range(0, kb.size()), noise_byte());
			default: begin
				kb.delete();
				repeat ($urandom_range(1, 8))
					kb.push_back(noise_byte());
			end
			endcase
		end
		foreach (kb[k]) begin
			if ($urandom_range(0, 19) == 0)
				pend_words.push_back('{b: 8'($urandom), present: 1'b0, last: 1'b0});
			pend_words.push_back('{b: kb[k], present: 1'b1, last: 1'b0});
		end
		if (kb.size() == 0 || $urandom_range(0, 4) == 0) begin
			pend_words.push_back('{b: 8'($urandom), present: 1'b0, last: 1'b1});
		end else begin
			w = pend_words[pend_words.size() - 1];
			w.last = 1'b1;
			pend_words[pend_words.size() - 1] = w;
		end
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// called at a rising edge; valid stays up across back-to-back words
	task send_word(key_word_t w, bit typed, parse_res_t typed_res);
		parse_res_t want;
		while ($urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.key_byte <= w.b;
		in_ch.byte_present <= w.present;
		in_ch.last_byte <= w.last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		want = parse_result_for(w);
		results_due.push_back(typed ? typed_res : want);
		if (w.present || w.last)
			words_in++;
	endtask

	task hold_until_drained();
		in_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task set_default_id(logic [31:0] v);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DEFAULT_ID_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		// read back straight after the write
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_default = v;
		check_field("default id readback", rd, v);
	endtask

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : result_check
		parse_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("mismatch: result word with nothing expected");
			end else begin
				want = results_due.pop_front();
				check_field("cache_key_byte", out_ch.cache_key_byte, want.cache_key_byte);
				check_field("cache_key_valid", out_ch.cache_key_valid, want.cache_key_valid);
				check_field("parse_done", out_ch.parse_done, want.parse_done);
				check_field("parse_ok", out_ch.parse_ok, want.parse_ok);
				check_field("private_out", out_ch.private_out, want.private_out);
				check_field("in_browser_out", out_ch.in_browser_out, want.in_browser_out);
				check_field("anonymous_out", out_ch.anonymous_out, want.anonymous_out);
				check_field("app_id_out", out_ch.app_id_out, want.app_id_out);
				if (want.parse_done && want.parse_ok)
					keys_ok++;
				else if (want.parse_done)
					keys_bad++;
				if (want.cache_key_valid)
					key_bytes_out++;
			end
		end
	end

	initial begin
		#400_000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] phase_id[4];
		int sent;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.key_byte = '0;
		in_ch.byte_present = 1'b0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		words_in = 0;
		results_seen = 0;
		keys_ok = 0;
		keys_bad = 0;
		key_bytes_out = 0;
		cfg_default = '0;
		pm_held = '0;
		key_restart();

		// empty key right after reset reports the cleared default id
		add_row(8'h00, 1'b0, 1'b1, 1'b1, result_word(8'h00, 0, 1, 1, 0, 0, 0, 32'h0));
		// neither present nor last: no effect
		add_row(8'hFF, 1'b0, 1'b0, 1'b1, '0);
		add_text("p,b,a,i4294967295,:");
		add_row(8'h00, 1'b1, 1'b0, 1'b1, result_word(8'h00, 1, 0, 0, 0, 0, 0, 32'h0));
		add_row(8'hFF, 1'b1, 1'b1, 1'b1,
			result_word(8'hFF, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF));
		// flag tag without its comma; the colon after the error is ignored
		add_text("pq");
		add_row(CH_COLON, 1'b1, 1'b1, 1'b1, result_word(8'h00, 0, 1, 0, 0, 0, 0, 32'h0));
		// unknown tag as the last byte leaves its value unclosed
		add_row(8'h78, 1'b1, 1'b1, 1'b1, result_word(8'h00, 0, 1, 0, 0, 0, 0, 32'h0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);

		phase_id[0] = 32'hFFFF_FFFF;
		phase_id[1] = $urandom;
		phase_id[2] = 32'h0000_0000;
		phase_id[3] = 32'h0000_0001;
		for (int ph = 0; ph < 4; ph++) begin
			hold_until_drained();
			set_default_id(phase_id[ph]);
			@(posedge clk);
			gap_pct = (ph == 1) ? 49 : (ph == 3) ? 6 : 0;
			stall_pct = (ph == 2) ? 49 : (ph == 3) ? 6 : 0;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if (pend_words.size() == 0)
					gen_key();
				if (pend_words[0].present || pend_words[0].last)
					sent++;
				send_word(pend_words.pop_front(), 1'b0, '0);
				if (ph == 1 && sent == PHASE_WORDS / 2)
					hold_until_drained();
			end
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d key words: %0d keys parsed, %0d rejected, %0d cache key bytes",
			words_in, keys_ok, keys_bad, key_bytes_out);
		$display("%0d result words checked under 5 default id settings and 4 flow patterns",
			results_seen);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

[cache_key_tag_parser_unit.f]
+incdir+rtl
rtl/ckp_pkg.sv
rtl/ckp_in_if.sv
rtl/ckp_out_if.sv
rtl/ckp_step.sv
rtl/cache_key_tag_parser_unit.sv
tb/testbench.sv
